>>> sv/stt_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the subarray target sum counter.
package stt_pkg;

  localparam int unsigned TABLE_ENTRIES_DEF = 1024;
  localparam int unsigned KEY_W = 32;
  localparam int unsigned FREQ_W = 11;
  localparam int unsigned EPOCH_W = 8;
  localparam logic [KEY_W-1:0] HASH_MULT = 32'd2654435761;

  typedef logic [EPOCH_W-1:0] epoch_t;

  typedef struct packed {
    epoch_t tag;
    logic [FREQ_W-1:0] freq;
    logic [KEY_W-1:0] key;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

endpackage

>>> sv/stt_ram.sv
`timescale 1ns / 1ps
// Generic simple dual-port RAM with registered read.
module stt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> sv/stt_hash.sv
`timescale 1ns / 1ps
// Home slot unit: multiplicative hash, xor fold, reduction to table size.
module stt_hash #(
  parameter int unsigned ENTRIES = stt_pkg::TABLE_ENTRIES_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [stt_pkg::KEY_W-1:0]  key,
  output logic                       done,
  output logic [$clog2(ENTRIES)-1:0] slot
);

  localparam int unsigned AW = $clog2(ENTRIES);
  localparam int unsigned KW = stt_pkg::KEY_W;
  localparam int unsigned PW = 2 * KW;
  localparam bit IS_POW2 = ((64'd1 << AW) == 64'(ENTRIES));
  // floor(2^(31+AW) / ENTRIES) fits in KW bits; quotient estimate is low by at most one
  localparam logic [KW-1:0] RECIP = KW'((64'd1 << (31 + AW)) / 64'(ENTRIES));
  localparam logic [KW-1:0] SIZE = KW'(ENTRIES);

  typedef enum logic [1:0] {H_IDLE, H_MIX, H_QMUL, H_FIX} hstate_t;

  hstate_t state;
  logic [KW-1:0] mul_q;
  logic [KW-1:0] mix;
  logic [KW-1:0] quo;
  logic [KW-1:0] rem;
  logic [KW-1:0] rem_fix;
  logic [KW-1:0] mul_a;
  logic [KW-1:0] mul_b;
  logic [PW-1:0] mul_p;

  assign mix = mul_q ^ (mul_q >> 16);
  assign mul_p = PW'(mul_a) * PW'(mul_b);
  assign rem_fix = (rem >= SIZE) ? rem - SIZE : rem;

  // one multiplier shared by the hash, the reciprocal and the back-multiply steps
  always_comb begin
    mul_a = key;
    mul_b = stt_pkg::HASH_MULT;
    case (state)
      H_MIX: begin
        mul_a = mix;
        mul_b = RECIP;
      end
      H_QMUL: begin
        mul_a = quo;
        mul_b = SIZE;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= H_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        H_IDLE: begin
          if (start) begin
            mul_q <= mul_p[KW-1:0];
            state <= H_MIX;
          end
        end
        H_MIX: begin
          if (IS_POW2) begin
            slot  <= mix[AW-1:0];
            done  <= 1'b1;
            state <= H_IDLE;
          end else begin
            quo   <= KW'(mul_p >> (31 + AW));
            state <= H_QMUL;
          end
        end
        H_QMUL: begin
          rem   <= mix - mul_p[KW-1:0];
          state <= H_FIX;
        end
        H_FIX: begin
          slot  <= rem_fix[AW-1:0];
          done  <= 1'b1;
          state <= H_IDLE;
        end
        default: state <= H_IDLE;
      endcase
    end
  end

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> state == H_IDLE) else $error("hash done outside idle");
  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    start |-> state == H_IDLE) else $error("hash started while busy");
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("hash done longer than one cycle");

endmodule

>>> sv/subarray_target_sum_counter.sv
`timescale 1ns / 1ps
// Top level: counts contiguous runs summing to target_sum via prefix-sum hash table.
// Per element: hash and probe the table for prefix minus target, then hash and probe
// again to insert or count the new prefix sum; a first element is preceded by a seed step.
// One element in flight: a new item is accepted only once the last result is issued.
// Reset (synchronous, active high) runs a clearing pass over every slot plus a
// seed step with in_ready low; every 255th first element repeats that pass.
module subarray_target_sum_counter #(
  parameter int unsigned TABLE_ENTRIES = stt_pkg::TABLE_ENTRIES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] target_sum,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] element,
  input  logic        first,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] run_count,
  output logic        table_overflow
);

  localparam int unsigned AW = $clog2(TABLE_ENTRIES);
  localparam logic [AW-1:0] LAST_SLOT = AW'(TABLE_ENTRIES - 1);

  typedef enum logic [2:0] {
    S_CLEAR, S_SEED, S_IDLE, S_HASH_GO, S_HASH_WAIT, S_PROBE_RD, S_PROBE_CMP, S_DONE
  } state_t;

  state_t state;
  logic busy;
  logic phase;
  logic [31:0] target;
  logic [31:0] prefix_sum;
  logic [31:0] prefix_next;
  logic [31:0] match_total;
  logic overflow;
  logic [stt_pkg::KEY_W-1:0] probe_key;
  stt_pkg::epoch_t epoch;
  logic [AW-1:0] clr_idx;
  logic [AW-1:0] slot;
  logic [AW-1:0] slot_adv;
  logic [AW-1:0] probe_cnt;
  logic [32:0] total_sum;

  logic hash_start;
  logic hash_done;
  logic [AW-1:0] hash_slot;

  logic ram_we;
  logic [AW-1:0] ram_waddr;
  logic [AW-1:0] ram_raddr;
  stt_pkg::entry_t wentry;
  stt_pkg::entry_t rentry;
  logic [stt_pkg::ENTRY_W-1:0] ram_rdata;

  logic hit_live;
  logic hit_match;
  logic hit_empty;
  logic exhausted;

  assign cfg_ready = 1'b1;
  assign in_ready = (state == S_IDLE);
  assign hash_start = (state == S_HASH_GO);

  assign prefix_next = (first ? 32'd0 : prefix_sum) + element;
  assign slot_adv = (slot == LAST_SLOT) ? '0 : slot + AW'(1);
  assign total_sum = {1'b0, match_total} + 33'(rentry.freq);

  assign rentry = stt_pkg::entry_t'(ram_rdata);
  assign hit_live = (rentry.tag == epoch);
  assign hit_match = hit_live && (rentry.key == probe_key);
  assign hit_empty = !hit_live;
  assign exhausted = (probe_cnt == LAST_SLOT);

  always_comb begin
    ram_we = 1'b0;
    ram_waddr = slot;
    wentry = '0;
    ram_raddr = (state == S_PROBE_CMP) ? slot_adv : slot;
    case (state)
      S_CLEAR: begin
        ram_we = 1'b1;
        ram_waddr = clr_idx;
      end
      S_SEED: begin
        ram_we = 1'b1;
        ram_waddr = '0;
        wentry.tag = epoch;
        wentry.freq = stt_pkg::FREQ_W'(1);
      end
      S_PROBE_CMP: begin
        if (phase && (hit_match || hit_empty)) begin
          ram_we = 1'b1;
          if (hit_match) begin
            wentry = rentry;
            if (rentry.freq != '1) begin
              wentry.freq = rentry.freq + stt_pkg::FREQ_W'(1);
            end
          end else begin
            wentry.tag = epoch;
            wentry.freq = stt_pkg::FREQ_W'(1);
            wentry.key = probe_key;
          end
        end
      end
      default: ;
    endcase
  end

  stt_hash #(.ENTRIES(TABLE_ENTRIES)) u_hash (
    .clk   (clk),
    .rst   (rst),
    .start (hash_start),
    .key   (probe_key),
    .done  (hash_done),
    .slot  (hash_slot)
  );

  stt_ram #(.WIDTH(stt_pkg::ENTRY_W), .DEPTH(TABLE_ENTRIES)) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (wentry),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      target      <= '0;
      state       <= S_CLEAR;
      busy        <= 1'b0;
      phase       <= 1'b0;
      epoch       <= stt_pkg::epoch_t'(1);
      clr_idx     <= '0;
      prefix_sum  <= '0;
      match_total <= '0;
      overflow    <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_valid) begin
        target <= target_sum;
      end
      if (out_valid && out_ready && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clr_idx <= (clr_idx == LAST_SLOT) ? '0 : clr_idx + AW'(1);
          if (clr_idx == LAST_SLOT) begin
            state <= S_SEED;
          end
        end
        S_SEED: begin
          state <= busy ? S_HASH_GO : S_IDLE;
        end
        S_IDLE: begin
          if (in_valid) begin
            busy       <= 1'b1;
            phase      <= 1'b0;
            prefix_sum <= prefix_next;
            probe_key  <= prefix_next - target;
            if (first) begin
              match_total <= '0;
              overflow    <= 1'b0;
              if (epoch == '1) begin
                epoch <= stt_pkg::epoch_t'(1);
                state <= S_CLEAR;
              end else begin
                epoch <= epoch + stt_pkg::epoch_t'(1);
                state <= S_SEED;
              end
            end else begin
              state <= S_HASH_GO;
            end
          end
        end
        S_HASH_GO: begin
          state <= S_HASH_WAIT;
        end
        S_HASH_WAIT: begin
          if (hash_done) begin
            slot      <= hash_slot;
            probe_cnt <= '0;
            state     <= S_PROBE_RD;
          end
        end
        S_PROBE_RD: begin
          state <= S_PROBE_CMP;
        end
        S_PROBE_CMP: begin
          if (!phase) begin
            if (hit_match || hit_empty || exhausted) begin
              if (hit_match) begin
                match_total <= total_sum[32] ? '1 : total_sum[31:0];
              end
              phase     <= 1'b1;
              probe_key <= prefix_sum;
              state     <= S_HASH_GO;
            end else begin
              slot      <= slot_adv;
              probe_cnt <= probe_cnt + AW'(1);
            end
          end else begin
            if (hit_match || hit_empty) begin
              state <= S_DONE;
            end else if (exhausted) begin
              overflow <= 1'b1;
              state    <= S_DONE;
            end else begin
              slot      <= slot_adv;
              probe_cnt <= probe_cnt + AW'(1);
            end
          end
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid      <= 1'b1;
            run_count      <= match_total;
            table_overflow <= overflow;
            busy           <= 1'b0;
            state          <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_no_write_idle: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !ram_we) else $error("table write while idle");
  a_epoch_live: assert property (@(posedge clk) disable iff (rst)
    epoch != '0) else $error("epoch took the cleared tag");
  a_overflow_clear: assert property (@(posedge clk) disable iff (rst)
    $fell(overflow) && !$past(rst) |-> $past(in_valid && in_ready && first))
    else $error("overflow dropped without a new array");
  a_idle_not_busy: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !busy) else $error("idle with an item in flight");

endmodule

>>> dv/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for subarray_target_sum_counter: predicts each run count and overflow.
module tb_top;

  localparam int unsigned SLOTS = stt_pkg::TABLE_ENTRIES_DEF;
  localparam logic [31:0] GOLDEN_MULT = 32'h9E3779B1;
  localparam logic [10:0] FREQ_CAP = 11'h7FF;
  localparam int unsigned CYCLE_LIMIT = 3000000;
  localparam int unsigned SETTLE_CYCLES = 100;

  typedef struct {
    logic [31:0] count;
    logic        ovf;
  } tally_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [31:0] target_sum = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [31:0] element = '0;
  logic        first = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] run_count;
  logic        table_overflow;

  // prefix-sum table mirror
  logic [31:0] sum_key [SLOTS];
  logic [10:0] sum_freq [SLOTS];
  bit          sum_live [SLOTS];
  logic [31:0] run_sum;
  logic [31:0] match_sum;
  logic [31:0] goal;
  bit          overflowed;

  tally_t      expected_tallies [$];
  tally_t      oldest;
  int          error_count = 0;
  int unsigned cycle_count = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int          hold_left = 0;

  subarray_target_sum_counter DUT (
    .clk            (clk),
    .rst            (rst),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .target_sum     (target_sum),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .element        (element),
    .first          (first),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .run_count      (run_count),
    .table_overflow (table_overflow)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic int home_of(input logic [31:0] key);
    logic [31:0] h;
    h = key * GOLDEN_MULT;
    h = h ^ (h >> 16);
    return int'(h % SLOTS);
  endfunction

  // slot holding key, else first free slot on its path, else -1
  function automatic int find_slot(input logic [31:0] key);
    int s;
    s = home_of(key);
    for (int n = 0; n < SLOTS; n++) begin
      if (!sum_live[s] || sum_key[s] == key) return s;
      s++;
      if (s == SLOTS) s = 0;
    end
    return -1;
  endfunction

  task automatic record_sum(input logic [31:0] key);
    int s;
    s = find_slot(key);
    if (s < 0) begin
      overflowed = 1'b1;
    end else if (sum_live[s]) begin
      if (sum_freq[s] != FREQ_CAP) sum_freq[s] = sum_freq[s] + 11'd1;
    end else begin
      sum_live[s] = 1'b1;
      sum_key[s] = key;
      sum_freq[s] = 11'd1;
    end
  endtask

  task automatic reseed_table();
    for (int i = 0; i < SLOTS; i++) sum_live[i] = 1'b0;
    run_sum = '0;
    match_sum = '0;
    overflowed = 1'b0;
    record_sum('0);
  endtask

  task automatic tally_element(input logic [31:0] elem, input logic is_first);
    logic [31:0] want;
    logic [32:0] acc;
    int s;
    tally_t t;
    if (is_first) reseed_table();
    run_sum = run_sum + elem;
    want = run_sum - goal;
    s = find_slot(want);
    if (s >= 0 && sum_live[s]) begin
      acc = {1'b0, match_sum} + 33'(sum_freq[s]);
      match_sum = acc[32] ? 32'hFFFF_FFFF : acc[31:0];
    end
    record_sum(run_sum);
    t.count = match_sum;
    t.ovf = overflowed;
    expected_tallies.push_back(t);
  endtask

  task automatic send_element(input logic [31:0] elem, input logic is_first);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      element <= $urandom();
      first <= 1'($urandom_range(1));
      @(negedge clk);
    end
    in_valid <= 1'b1;
    element <= elem;
    first <= is_first;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    tally_element(elem, is_first);
  endtask

  task automatic wait_for_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_tallies.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_target(input logic [31:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    target_sum <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    goal = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [31:0] pick_element();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 70) return $urandom_range(8) - 4;
    if (r < 85) return $urandom();
    case ($urandom_range(3))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'hFFFF_FFFF;
      default: return 32'h0;
    endcase
  endfunction

  function automatic logic [31:0] pick_target();
    if ($urandom_range(3) == 0) return $urandom();
    return $urandom_range(10) - 5;
  endfunction

  // receiver: random stalls, plus long hold-offs on request
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (expected_tallies.size() == 0) begin
        error_count++;
        $display("%0t: unexpected item: expected none, actual run_count=%0d overflow=%0b",
                 $time, run_count, table_overflow);
      end else begin
        oldest = expected_tallies.pop_front();
        if (run_count !== oldest.count) begin
          error_count++;
          $display("%0t: run_count mismatch: expected %0d actual %0d",
                   $time, oldest.count, run_count);
        end
        if (table_overflow !== oldest.ovf) begin
          error_count++;
          $display("%0t: table_overflow mismatch: expected %0b actual %0b",
                   $time, oldest.ovf, table_overflow);
        end
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  task automatic test_before_first();
    send_element(32'h7FFF_FFFF, 1'b0);
    send_element(32'h0000_0001, 1'b0);
    send_element(32'h8000_0000, 1'b0);
    send_element(32'hFFFF_FFFF, 1'b0);
    send_element(32'h0000_0001, 1'b0);
    send_element(32'h0000_0000, 1'b0);
    wait_for_results();
  endtask

  task automatic test_extremes();
    write_target(32'h8000_0000);
    send_element(32'h8000_0000, 1'b1);
    send_element(32'h8000_0000, 1'b0);
    send_element(32'h0000_0000, 1'b0);
    wait_for_results();
    write_target(32'h7FFF_FFFF);
    send_element(32'h7FFF_FFFF, 1'b1);
    send_element(32'h7FFF_FFFF, 1'b0);
    send_element(32'h0000_0002, 1'b0);
    send_element(32'h8000_0000, 1'b0);
    wait_for_results();
    write_target(32'hFFFF_FFFF);
    send_element(32'hFFFF_FFFF, 1'b1);
    send_element(32'hFFFF_FFFF, 1'b0);
    send_element(32'h0000_0001, 1'b0);
    send_element(32'h0000_0005, 1'b1);
    send_element(32'h0000_0005, 1'b1);
    wait_for_results();
    write_target(32'h0000_0001);
    send_element(32'h0000_0001, 1'b1);
    send_element(32'h0000_0001, 1'b1);
    send_element(32'h0000_0000, 1'b0);
    send_element(32'h0000_0001, 1'b0);
    wait_for_results();
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_target(32'h3);
    send_element(pick_element(), 1'b1);
    hold_left = 400;
    repeat (20) send_element(pick_element(), 1'b0);
    wait_for_results();
    repeat (10) send_element(pick_element(), 1'b0);
    wait_for_results();
    repeat (10) send_element(pick_element(), 1'b0);
    wait_for_results();
  endtask

  task automatic test_random_stream();
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin send_idle_pct = 23; recv_idle_pct = 80; end
        1: begin send_idle_pct = 80; recv_idle_pct = 23; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      for (int blk = 0; blk < 5; blk++) begin
        write_target(pick_target());
        for (int i = 0; i < 45; i++)
          send_element(pick_element(), $urandom_range(99) < 4);
        wait_for_results();
      end
    end
  endtask

  initial begin
    goal = '0;
    reseed_table();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_before_first();
    test_extremes();
    test_backpressure();
    test_random_stream();
    while (expected_tallies.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

>>> sim.f
sv/stt_pkg.sv
sv/stt_ram.sv
sv/stt_hash.sv
sv/subarray_target_sum_counter.sv
dv/tb_top.sv
